@@ rtl/core/tor_pkg.sv @@
package tor_pkg;

  // telnet command bytes
  localparam logic [7:0] TN_IAC  = 8'hFF;
  localparam logic [7:0] TN_WILL = 8'hFB;
  localparam logic [7:0] TN_WONT = 8'hFC;
  localparam logic [7:0] TN_DO   = 8'hFD;
  localparam logic [7:0] TN_DONT = 8'hFE;
  localparam logic [7:0] TN_MARK = 8'hFE;

  // commands that are dropped together with their iac
  localparam logic [7:0] CMD_DROP_SINGLE = 8'd241;
  localparam logic [7:0] CMD_DROP_LO     = 8'd243;
  localparam logic [7:0] CMD_DROP_HI     = 8'd250;

  localparam logic [7:0] ACCEPTED_OPTION_RESET = 8'd3;
  localparam logic       REPLY_ENABLE_RESET    = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_ACCEPTED_OPTION = 1'b0;
  localparam logic REG_REPLY_ENABLE    = 1'b1;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_CMD,
    PH_OPT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_MARK,
    KIND_REPLY
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] code;
    logic [7:0] value;
  } action_t;

  typedef struct packed {
    logic [7:0] accepted_option;
    logic       reply_enable;
  } cfg_t;

  function automatic logic [7:0] data_byte(input logic [7:0] b);
    return (b == 8'd0) ? 8'd1 : b;
  endfunction

  // index of the final result of an action
  function automatic logic [1:0] last_step(input kind_t kind);
    logic [1:0] r;
    r = 2'd0;
    case (kind)
      KIND_DATA:  r = 2'd0;
      KIND_MARK:  r = 2'd1;
      KIND_REPLY: r = 2'd2;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/tor_front.sv @@
module tor_front (
  input  logic            clk,
  input  logic            rst,
  input  tor_pkg::cfg_t   cfg,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            queue_full,
  output logic            in_ready,
  output logic            push,
  output tor_pkg::action_t push_entry
);
  import tor_pkg::*;

  phase_t       phase;
  phase_t       phase_next;
  logic         peer_offers;
  logic         peer_offers_next;
  logic         answered [256];
  logic         seen;
  logic         clr_active;
  logic [7:0]   clr_addr;
  logic         accept;
  logic         is_nego;
  logic         is_drop;
  logic         want;
  action_t      entry;
  logic         stg_valid;
  logic         stg_want;
  logic         stg_opt;
  action_t      stg_entry;
  logic         stg_push_req;
  logic         stg_done;
  logic         set_answered;

  // one classified byte waits in the stage while its answered flag is read
  assign stg_push_req = stg_valid && stg_want &&
                        (!stg_opt || (!seen && cfg.reply_enable));
  assign stg_done     = stg_valid && !(stg_push_req && queue_full);
  assign push         = stg_push_req && !queue_full;
  assign push_entry   = stg_entry;
  assign set_answered = stg_done && stg_opt && !seen;

  assign in_ready = !clr_active && (!stg_valid || stg_done);
  assign accept   = in_valid && in_ready;
  assign is_nego  = (in_byte >= TN_WILL) && (in_byte <= TN_DONT);
  assign is_drop  = (in_byte == CMD_DROP_SINGLE) || (in_byte == TN_IAC) ||
                    ((in_byte >= CMD_DROP_LO) && (in_byte <= CMD_DROP_HI));

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_CMD:  phase_next = is_nego ? PH_OPT : PH_DATA;
        PH_OPT:  phase_next = PH_DATA;
        default: phase_next = (in_byte == TN_IAC) ? PH_CMD : PH_DATA;
      endcase
    end
  end

  always_comb begin
    want             = 1'b0;
    entry.kind       = KIND_DATA;
    entry.code       = TN_IAC;
    entry.value      = data_byte(in_byte);
    peer_offers_next = peer_offers;
    if (accept) begin
      unique case (phase)
        PH_CMD: begin
          if (is_nego) begin
            peer_offers_next = (in_byte <= TN_WONT);
          end else if (!is_drop) begin
            want       = 1'b1;
            entry.kind = KIND_MARK;
          end
        end
        PH_OPT: begin
          want        = 1'b1;
          entry.kind  = KIND_REPLY;
          entry.value = in_byte;
          if (peer_offers) begin
            entry.code = (in_byte == cfg.accepted_option) ? TN_DO : TN_DONT;
          end else begin
            entry.code = (in_byte == cfg.accepted_option) ? TN_WILL : TN_WONT;
          end
        end
        default: begin
          want = (in_byte != TN_IAC);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_DATA;
      peer_offers <= 1'b0;
      stg_valid   <= 1'b0;
      clr_active  <= 1'b1;
      clr_addr    <= '0;
    end else begin
      phase       <= phase_next;
      peer_offers <= peer_offers_next;
      if (accept) begin
        stg_valid <= 1'b1;
      end else if (stg_done) begin
        stg_valid <= 1'b0;
      end
      if (clr_active) begin
        clr_addr <= clr_addr + 8'd1;
        if (clr_addr == 8'hFF) begin
          clr_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_want  <= want;
      stg_opt   <= (phase == PH_OPT);
      stg_entry <= entry;
    end
  end

  // answered-option flags: cleared one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (clr_active) begin
      answered[clr_addr] <= 1'b0;
    end else if (set_answered) begin
      answered[stg_entry.value] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seen <= answered[in_byte];
    end
  end

endmodule

@@ rtl/core/tor_queue.sv @@
module tor_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tor_pkg::action_t push_entry,
  input  logic             pop,
  output tor_pkg::action_t head,
  output logic             empty,
  output logic             full
);
  import tor_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  action_t       slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign empty   = (count == '0);
  assign full    = (count == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/tor_back.sv @@
module tor_back (
  input  logic             clk,
  input  logic             rst,
  input  tor_pkg::action_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             to_peer,
  output logic             last_of_run
);
  import tor_pkg::*;

  action_t    cur;
  logic       cur_valid;
  logic [1:0] step;

  assign out_valid   = cur_valid;
  assign last_of_run = (step == last_step(cur.kind));
  assign to_peer     = (cur.kind == KIND_REPLY);
  assign pop         = !empty && (!cur_valid || (out_ready && last_of_run));

  always_comb begin
    out_byte = cur.value;
    case (cur.kind)
      KIND_MARK: begin
        if (step == 2'd0) out_byte = TN_MARK;
      end
      KIND_REPLY: begin
        if (step == 2'd0) out_byte = TN_IAC;
        else if (step == 2'd1) out_byte = cur.code;
      end
      default: out_byte = cur.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      step      <= 2'd0;
    end else if (cur_valid && out_ready) begin
      if (last_of_run) begin
        cur_valid <= 1'b0;
        step      <= 2'd0;
      end else begin
        step <= step + 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/telnet_option_responder_core.sv @@
// telnet option responder: one received byte per cycle in while s_tready is high, one result
//   byte per cycle out while m_tready is high; the first result of a byte passes the classify
//   stage, the action queue and the back end's action register before it shows on m_tvalid
// throughput: one input byte per cycle while the action queue has room; the back end drains
//   one result per cycle while m_tready is high, so three-byte replies keep pace with three-byte commands
// reset: synchronous, clears the parse phase and the queue, loads accepted_option 3 and
//   reply_enable 1, then s_tready stays low while all 256 answered-option flags are cleared
//   one per cycle
module telnet_option_responder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,

  // received byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte

  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tuser,   // [0] to_peer
  output logic        m_tlast,   // last_of_run

  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tor_pkg::*;

  cfg_t    cfg;
  logic    cfg_write;
  logic    push;
  action_t push_entry;
  logic    pop;
  action_t head;
  logic    queue_empty;
  logic    queue_full;

  // apb register file, always ready
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accepted_option <= ACCEPTED_OPTION_RESET;
      cfg.reply_enable    <= REPLY_ENABLE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_ACCEPTED_OPTION: cfg.accepted_option <= pwdata[7:0];
        REG_REPLY_ENABLE:    cfg.reply_enable    <= pwdata[0];
        default:             cfg.reply_enable    <= cfg.reply_enable;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACCEPTED_OPTION: prdata = {24'd0, cfg.accepted_option};
      REG_REPLY_ENABLE:    prdata = {31'd0, cfg.reply_enable};
      default:             prdata = 32'd0;
    endcase
  end

  // front end: parses iac sequences, tracks answered options, queues actions
  tor_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .queue_full (queue_full),
    .in_ready   (s_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  // short action queue so the input side and the output side stall apart
  tor_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (queue_empty),
    .full       (queue_full)
  );

  // back end: expands each action into one to three result transfers
  tor_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (queue_empty),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .to_peer     (m_tuser),
    .last_of_run (m_tlast)
  );

endmodule
